>>> sv/firq15_pkg.sv
package firq15_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned COEF_W      = 16;
  localparam int unsigned TAP_COUNT_W = 7;
  localparam int unsigned COEF_IDX_W  = 6;
  localparam int unsigned PROD_W      = SAMPLE_W + COEF_W;

  // Default tap store depth
  localparam int unsigned MAX_TAPS_DEF = 64;

  // Q15 scaling and int16 limits
  localparam int unsigned Q_SHIFT       = 15;
  localparam int          Q15_POS_LIMIT = 32767;
  localparam int          Q15_NEG_LIMIT = -32768;

  // Reset value of the tap count register
  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = TAP_COUNT_W'(1);

  // Operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  typedef struct packed {
    logic                       op;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       last_of_block;
    logic [COEF_IDX_W-1:0]      coef_index;
    logic signed [COEF_W-1:0]   coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       saturated;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic coef_we;      // store one coefficient from the request
    logic sample_take;  // shift the sample in and arm the tap sweep
    logic issue;        // read one tap pair
    logic load_out;     // scale, clip and present the result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic run_done;     // every tap pair of this sample has been read
    logic pipe_busy;    // products still on their way to the accumulator
    logic out_full;     // result register holds a result not yet taken
  } status_t;

endpackage

>>> sv/firq15_ctrl.sv
module firq15_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_op_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  input  firq15_pkg::status_t status_i,
  output firq15_pkg::cmd_t    cmd_o
);
  import firq15_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   accept;
  logic   out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !status_i.out_full || out_ready_i;

  // Decode commands and next state
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_op_i == OP_COEF) begin
            cmd_o.coef_we = 1'b1;
          end else begin
            cmd_o.sample_take = 1'b1;
            state_d           = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (status_i.run_done) begin
          state_d = ST_DRAIN;
        end else begin
          cmd_o.issue = 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/firq15_datapath.sv
module firq15_datapath #(
  parameter int unsigned MAX_TAPS = firq15_pkg::MAX_TAPS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  firq15_pkg::in_item_t                   in_item_i,
  input  logic                                   cfg_we_i,
  input  logic [firq15_pkg::TAP_COUNT_W-1:0]     cfg_wdata_i,
  input  firq15_pkg::cmd_t                       cmd_i,
  output firq15_pkg::status_t                    status_o,
  input  logic                                   out_ready_i,
  output logic                                   out_valid_o,
  output firq15_pkg::out_item_t                  out_item_o
);
  import firq15_pkg::*;

  localparam int unsigned AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned CW    = $clog2(MAX_TAPS + 1);
  localparam int unsigned ACC_W = PROD_W + CW;

  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(MAX_TAPS);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(Q15_POS_LIMIT);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(Q15_NEG_LIMIT);

  // Tap store and history ring
  logic signed [COEF_W-1:0]   coef_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]        coef_vld_q;
  logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];

  logic [TAP_COUNT_W-1:0] tap_count_q;
  logic [CW-1:0]          filled_q, fill_next;
  logic [CW-1:0]          rem_q, usable_d;
  logic [AW-1:0]          wptr_q, rptr_q, caddr_q, coef_waddr;
  logic                   coef_in_range;
  logic                   last_q;
  logic [31:0]            taps32, usable32;

  // Pipeline
  logic                       v1_q, v2_q;
  logic signed [COEF_W-1:0]   coef_rd_q;
  logic                       coef_rd_vld_q;
  logic signed [SAMPLE_W-1:0] hist_rd_q;
  logic signed [COEF_W-1:0]   coef_eff;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc_q, scaled;

  logic      out_valid_q;
  out_item_t out_q, out_d;

  assign coef_in_range = ({{(32 - COEF_IDX_W){1'b0}}, in_item_i.coef_index} < 32'(MAX_TAPS));
  assign coef_waddr    = AW'(in_item_i.coef_index);

  // Count filled positions and clamp the tap count
  assign fill_next = (filled_q == FULL_CNT) ? filled_q : filled_q + 1'b1;
  assign taps32    = (32'(tap_count_q) > 32'(MAX_TAPS)) ? 32'(MAX_TAPS) : 32'(tap_count_q);
  assign usable32  = (taps32 < 32'(fill_next)) ? taps32 : 32'(fill_next);
  assign usable_d  = CW'(usable32);

  assign status_o.run_done  = (rem_q == '0);
  assign status_o.pipe_busy = v1_q || v2_q;
  assign status_o.out_full  = out_valid_q;

  // Write the tap store
  always_ff @(posedge clk_i) begin
    if (cmd_i.coef_we && coef_in_range) begin
      coef_mem[coef_waddr] <= in_item_i.coef_value;
    end
  end

  // Read the tap store
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      coef_rd_q     <= coef_mem[caddr_q];
      coef_rd_vld_q <= coef_vld_q[caddr_q];
    end
  end

  // Write and read the history ring
  always_ff @(posedge clk_i) begin
    if (cmd_i.sample_take) begin
      hist_mem[wptr_q] <= in_item_i.sample_in;
    end
    if (cmd_i.issue) begin
      hist_rd_q <= hist_mem[rptr_q];
    end
  end

  // Mark written taps; an unwritten tap reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q <= '0;
    end else if (cmd_i.coef_we && coef_in_range) begin
      coef_vld_q[coef_waddr] <= 1'b1;
    end
  end

  // Hold tap count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TAP_COUNT_RST;
    end else if (cfg_we_i) begin
      tap_count_q <= cfg_wdata_i;
    end
  end

  // Advance pointers and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q   <= '0;
      rptr_q   <= '0;
      caddr_q  <= '0;
      filled_q <= '0;
      rem_q    <= '0;
      last_q   <= 1'b0;
    end else begin
      if (cmd_i.sample_take) begin
        wptr_q   <= (wptr_q == LAST_ADDR) ? '0 : wptr_q + 1'b1;
        rptr_q   <= wptr_q;
        caddr_q  <= '0;
        filled_q <= fill_next;
        rem_q    <= usable_d;
        last_q   <= in_item_i.last_of_block;
      end else if (cmd_i.issue) begin
        rptr_q  <= (rptr_q == '0) ? LAST_ADDR : rptr_q - 1'b1;
        caddr_q <= caddr_q + 1'b1;
        rem_q   <= rem_q - 1'b1;
      end else if (cmd_i.load_out && last_q) begin
        filled_q <= '0;
      end
    end
  end

  // Track pipeline occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
    end
  end

  // Multiply one tap pair
  assign coef_eff = coef_rd_vld_q ? coef_rd_q : '0;

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      prod_q <= hist_rd_q * coef_eff;
    end
  end

  // Accumulate at full width
  always_ff @(posedge clk_i) begin
    if (cmd_i.sample_take) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // Scale by floor shift and clip to int16
  assign scaled = acc_q >>> Q_SHIFT;

  always_comb begin
    out_d = '0;
    priority if (scaled > SAT_HI) begin
      out_d.sample_out = SAMPLE_W'(Q15_POS_LIMIT);
      out_d.saturated  = 1'b1;
    end else if (scaled < SAT_LO) begin
      out_d.sample_out = SAMPLE_W'(Q15_NEG_LIMIT);
      out_d.saturated  = 1'b1;
    end else begin
      out_d.sample_out = scaled[SAMPLE_W-1:0];
      out_d.saturated  = 1'b0;
    end
  end

  // Hold result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

>>> sv/fir_filter_q15_saturating.sv
// Channel   Direction  Handshake               Payload
// request   in         in_valid_i / in_ready_o  in_item_i  (sample or coefficient write)
// result    out        out_valid_o / out_ready_i out_item_o (one per sample request)
// config    in         cfg_we_i                 cfg_wdata_i (tap count)
//
// A coefficient write is stored straight from the request. For a sample request,
// usable = min(tap count, samples in the block) tap pairs, one tap pair
// per cycle, are read from the tap store and the history ring, multiplied and summed.
// Reset clears the control state, marks every tap unwritten (reads as zero) and
// sets the tap count to 1. A stalled result is held in the output register while
// the next request is accepted; only a second finished result waits for it.
module fir_filter_q15_saturating #(
  parameter int unsigned MAX_TAPS = firq15_pkg::MAX_TAPS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  firq15_pkg::in_item_t               in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output firq15_pkg::out_item_t              out_item_o,
  input  logic                               cfg_we_i,
  input  logic [firq15_pkg::TAP_COUNT_W-1:0] cfg_wdata_i
);
  import firq15_pkg::*;

  cmd_t    cmd;
  status_t status;

  firq15_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_item_i.op),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  firq15_datapath #(
    .MAX_TAPS (MAX_TAPS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

>>> tb/fir_filter_q15_saturating_test.sv
`timescale 1ns / 100ps

module fir_filter_q15_saturating_test;
  import firq15_pkg::*;

  localparam int unsigned DEPTH        = MAX_TAPS_DEF;
  localparam int unsigned CLK_HALF     = 5;
  localparam int unsigned DRAIN_CYCLES = DEPTH + 20;
  localparam int unsigned RANDOM_ITEMS = 1200;

  // Filter predictor and result checker
  class fir_scoreboard;
    logic signed [COEF_W-1:0]   coef_store [DEPTH];
    logic signed [SAMPLE_W-1:0] history [DEPTH];
    int unsigned                filled;
    int unsigned                tap_count;
    out_item_t                  expected_q [$];
    int unsigned                errors;
    int unsigned                checked;
    int unsigned                clipped;

    function new();
      foreach (coef_store[k]) coef_store[k] = '0;
      foreach (history[k]) history[k] = '0;
      filled    = 0;
      tap_count = TAP_COUNT_RST;
      errors    = 0;
      checked   = 0;
      clipped   = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Predict the outcome of one accepted request
    function void note_request(in_item_t req);
      longint      acc;
      longint      scaled;
      int unsigned lim;
      int unsigned usable;
      out_item_t   res;
      if (req.op == OP_COEF) begin
        if (req.coef_index < DEPTH) coef_store[req.coef_index] = req.coef_value;
        return;
      end
      for (int k = DEPTH - 1; k > 0; k--) history[k] = history[k-1];
      history[0] = req.sample_in;
      if (filled < DEPTH) filled++;
      lim    = (tap_count > DEPTH) ? DEPTH : tap_count;
      usable = (lim < filled) ? lim : filled;
      acc = 0;
      for (int j = 0; j < usable; j++) acc += longint'(history[j]) * longint'(coef_store[j]);
      // floor division by 2^15, then clip to int16
      scaled = acc >>> Q_SHIFT;
      res.saturated = 1'b1;
      if (scaled > Q15_POS_LIMIT) res.sample_out = SAMPLE_W'(Q15_POS_LIMIT);
      else if (scaled < Q15_NEG_LIMIT) res.sample_out = SAMPLE_W'(Q15_NEG_LIMIT);
      else begin
        res.sample_out = SAMPLE_W'(scaled);
        res.saturated  = 1'b0;
      end
      expected_q.push_back(res);
      if (req.last_of_block) begin
        foreach (history[k]) history[k] = '0;
        filled = 0;
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Compare one accepted result with the oldest prediction
    task check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d (clip %0b) with none outstanding",
                         got.sample_out, got.saturated));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (want.saturated) clipped++;
      if (got.sample_out !== want.sample_out)
        report($sformatf("sample_out %0d, predicted %0d", got.sample_out, want.sample_out));
      if (got.saturated !== want.saturated)
        report($sformatf("saturated %0b, predicted %0b", got.saturated, want.saturated));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   req_valid = 1'b0;
  logic                   req_ready;
  in_item_t               req_item = '0;
  logic                   res_valid;
  logic                   res_ready = 1'b0;
  out_item_t              res_item;
  logic                   cfg_we = 1'b0;
  logic [TAP_COUNT_W-1:0] cfg_wdata = '0;

  fir_scoreboard sb = new();
  bit            no_idle = 1'b0;
  int            ready_gap = 0;
  int unsigned   items_sent = 0;
  int unsigned   coef_writes = 0;
  int unsigned   blocks_done = 0;
  int unsigned   settings_done = 0;

  fir_filter_q15_saturating #(
    .MAX_TAPS(DEPTH)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (req_valid),
    .in_ready_o (req_ready),
    .in_item_i  (req_item),
    .out_valid_o(res_valid),
    .out_ready_i(res_ready),
    .out_item_o (res_item),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  initial begin
    #6_000_000;
    $display("[%0t] timeout with %0d results outstanding", $realtime, sb.pending());
    $display("** fir_filter_q15_saturating: FAILED **");
    $finish;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 5);
  endfunction

  // Stall the result side between accepted results
  always @(negedge clk) begin
    if (ready_gap > 0) begin
      res_ready <= 1'b0;
      ready_gap <= ready_gap - 1;
    end else begin
      res_ready <= 1'b1;
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && res_valid && res_ready) begin
      sb.check_result(res_item);
      ready_gap <= draw_gap();
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return SAMPLE_W'(Q15_POS_LIMIT);
      1: return SAMPLE_W'(Q15_NEG_LIMIT);
      2: return SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [COEF_W-1:0] rand_coef(int style);
    case (style)
      0: return COEF_W'($urandom);
      1: return COEF_W'($urandom_range(24000, Q15_POS_LIMIT));
      2: return COEF_W'(int'($urandom_range(0, 2047)) - 1024);
      default: return $urandom_range(0, 1) ? COEF_W'(Q15_POS_LIMIT) : COEF_W'(Q15_NEG_LIMIT);
    endcase
  endfunction

  function automatic in_item_t make_sample(logic signed [SAMPLE_W-1:0] s, logic last);
    in_item_t r;
    r.op            = OP_SAMPLE;
    r.sample_in     = s;
    r.last_of_block = last;
    r.coef_index    = COEF_IDX_W'($urandom);
    r.coef_value    = COEF_W'($urandom);
    return r;
  endfunction

  function automatic in_item_t make_coef(int idx, logic signed [COEF_W-1:0] v);
    in_item_t r;
    r.op            = OP_COEF;
    r.sample_in     = SAMPLE_W'($urandom);
    r.last_of_block = 1'($urandom);
    r.coef_index    = COEF_IDX_W'(idx);
    r.coef_value    = v;
    return r;
  endfunction

  // Present one request after a random gap and hold it until accepted
  task automatic send_request(input in_item_t req);
    int gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req_item  <= req;
    do @(posedge clk); while (!req_ready);
    sb.note_request(req);
    items_sent++;
    if (req.op == OP_COEF) coef_writes++;
  endtask

  // Drain the block, then write the tap count register
  task automatic write_tap_count(input logic [TAP_COUNT_W-1:0] n);
    @(negedge clk);
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.tap_count = n;
    settings_done++;
  endtask

  // One block of samples, closed by last_of_block unless left open
  task automatic run_block(input int len, input int coef_style);
    logic last;
    no_idle = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_request(make_coef($urandom_range(0, DEPTH - 1), rand_coef(coef_style)));
      last = (i == len - 1) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 39) == 0);
      send_request(make_sample(rand_sample(), last));
    end
    blocks_done++;
  endtask

  initial begin
    int          tap_plan [5] = '{DEPTH, 0, 127, DEPTH + 1, 1};
    int          phase;
    int          style;
    int          budget;
    int          n_coefs;
    int unsigned next_tap;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset tap count of one, all coefficients zero
    send_request(make_sample(SAMPLE_W'(Q15_POS_LIMIT), 1'b0));
    send_request(make_coef(0, COEF_W'(Q15_POS_LIMIT)));
    send_request(make_coef(1, COEF_W'(Q15_NEG_LIMIT)));
    send_request(make_coef(DEPTH - 1, COEF_W'(Q15_NEG_LIMIT)));
    send_request(make_sample(SAMPLE_W'(Q15_NEG_LIMIT), 1'b0));
    send_request(make_sample(SAMPLE_W'(Q15_POS_LIMIT), 1'b1));

    // Full depth: clip low, clip high, coefficient write inside a block
    write_tap_count(TAP_COUNT_W'(DEPTH));
    send_request(make_sample(SAMPLE_W'(Q15_POS_LIMIT), 1'b0));
    send_request(make_sample(SAMPLE_W'(Q15_NEG_LIMIT), 1'b0));
    send_request(make_sample(SAMPLE_W'(Q15_POS_LIMIT), 1'b0));
    send_request(make_coef(5, COEF_W'(12345)));
    send_request(make_sample(SAMPLE_W'(100), 1'b0));
    send_request(make_sample(SAMPLE_W'(-200), 1'b1));
    send_request(make_sample(SAMPLE_W'(0), 1'b1));

    // Zero taps give zero; oversized tap count acts as full depth
    write_tap_count('0);
    send_request(make_sample(SAMPLE_W'(Q15_NEG_LIMIT), 1'b0));
    send_request(make_sample(SAMPLE_W'(Q15_POS_LIMIT), 1'b1));
    write_tap_count('1);
    send_request(make_sample(SAMPLE_W'(1), 1'b0));
    send_request(make_sample(SAMPLE_W'(-1), 1'b0));
    send_request(make_sample(SAMPLE_W'(Q15_NEG_LIMIT), 1'b1));

    // Random phases: new tap count, coefficient reload, blocks of samples
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (phase < 5) next_tap = tap_plan[phase];
      else if ($urandom_range(0, 4) == 0) next_tap = $urandom_range(0, 127);
      else next_tap = $urandom_range(1, DEPTH);
      write_tap_count(TAP_COUNT_W'(next_tap));
      style = $urandom_range(0, 3);
      if ($urandom_range(0, 4) == 0) begin
        for (int k = 0; k < DEPTH; k++) send_request(make_coef(k, rand_coef(style)));
      end else begin
        n_coefs = $urandom_range(3, 16);
        repeat (n_coefs) send_request(make_coef($urandom_range(0, DEPTH - 1), rand_coef(style)));
      end
      budget = items_sent + $urandom_range(60, 140);
      while (items_sent < budget) begin
        if ($urandom_range(0, 4) == 0) run_block($urandom_range(60, 90), style);
        else run_block($urandom_range(1, 20), style);
      end
      phase++;
    end

    // Let every outstanding result arrive
    @(negedge clk);
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d requests (%0d coefficient writes) over %0d blocks",
             items_sent, coef_writes, blocks_done);
    $display("%0d results checked, %0d clipped, %0d tap count settings, %0d mismatches",
             sb.checked, sb.clipped, settings_done, sb.errors);
    if (sb.errors == 0) begin
      $display("** fir_filter_q15_saturating: PASSED **");
    end else begin
      $display("** fir_filter_q15_saturating: FAILED **");
    end
    $finish;
  end

endmodule
